/* src/lrl_pkg.sv */
// Package for the login rate limiter: table sizing, register indexes, verdict codes,
// and the command/status structs between the controller and the datapath.
// No dependencies.
package lrl_pkg;

  localparam int N  = 64;
  localparam int IW = $clog2(N);
  localparam int CW = $clog2(N + 1);

  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    REG_FAIL_THRESHOLD = 3'd0,
    REG_BASE_DELAY     = 3'd1,
    REG_MAX_DELAY      = 3'd2,
    REG_EVICTION_TIME  = 3'd3,
    REG_RATE_COUNT     = 3'd4,
    REG_RATE_WINDOW    = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    V_ALLOW    = 2'd0,
    V_RATE     = 2'd1,
    V_COOLDOWN = 2'd2,
    V_BAD_PW   = 2'd3
  } verdict_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic rate;
    logic fail;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_busy;
  } status_t;

endpackage

/* src/lrl_ifs.sv */
// Valid/ready channel interfaces for login attempts and verdicts.
// No dependencies.
interface lrl_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] source_key;
  logic [31:0] now_seconds;
  logic        password_ok;
  modport source (output valid, source_key, now_seconds, password_ok, input ready);
  modport sink (input valid, source_key, now_seconds, password_ok, output ready);
endinterface

interface lrl_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  verdict;
  logic [15:0] fail_total;
  logic [15:0] cooldown;
  logic        table_full;
  modport source (output valid, verdict, fail_total, cooldown, table_full, input ready);
  modport sink (input valid, verdict, fail_total, cooldown, table_full, output ready);
endinterface

/* src/login_rate_limit_and_backoff_lockout.sv */
// Top level of the per-source login rate limiter with backoff lockout.
// Depends on lrl_pkg, lrl_ifs, lrl_ctrl and lrl_dp.
//
// Usage:
//   attempt: valid/ready channel carrying source_key, now_seconds, password_ok.
//   result:  valid/ready channel carrying verdict, fail_total, cooldown,
//            table_full; one result per attempt.
//   cfg_we/cfg_index/cfg_data: register writes, taken when cfg_we is high.
//   Each attempt is accepted, scanned against both 64-entry tables (one
//   entry per cycle through the registered table read port; the scan ends
//   once the last read has been compared), then takes a rate update and a
//   failure update. The next attempt is accepted only after the result
//   register loads; a new attempt is not taken while one is in progress.
//   If result is stalled, the finished result holds; the next attempt is
//   still accepted and scanned, then waits at its failure update.
//   Reset (rst, synchronous) empties both tables via valid bits, loads the
//   register defaults and drops any pending result; no clearing pass.
module login_rate_limit_and_backoff_lockout (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data,
  lrl_in_if.sink      attempt,
  lrl_out_if.source   result
);
  import lrl_pkg::*;

  cmd_t    cmd;
  status_t status;

  lrl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (attempt.valid),
    .in_ready (attempt.ready),
    .status   (status),
    .cmd      (cmd)
  );

  lrl_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_key    (attempt.source_key),
    .in_now    (attempt.now_seconds),
    .in_ok     (attempt.password_ok),
    .cmd       (cmd),
    .status    (status),
    .res       (result)
  );

endmodule

/* src/lrl_ctrl.sv */
// Controller FSM: accept, table scan, rate update, failure update.
// Depends on lrl_pkg.
module lrl_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  lrl_pkg::status_t status,
  output lrl_pkg::cmd_t    cmd
);
  import lrl_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_RATE = 4'b0100,
    S_FAIL = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_SCAN;
      S_SCAN: if (status.scan_done) state_next = S_RATE;
      S_RATE: state_next = S_FAIL;
      S_FAIL: if (!status.out_busy) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign in_ready  = (state == S_IDLE);
  assign cmd.start = (state == S_IDLE) && in_valid;
  assign cmd.scan  = (state == S_SCAN);
  assign cmd.rate  = (state == S_RATE);
  assign cmd.fail  = (state == S_FAIL) && !status.out_busy;

endmodule

/* src/lrl_dp.sv */
// Datapath: config registers, rate and failure tables, scan search registers,
// update logic and output register. Depends on lrl_pkg and lrl_ifs.
module lrl_dp (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [19:0]        cfg_data,
  input  logic [63:0]        in_key,
  input  logic [31:0]        in_now,
  input  logic               in_ok,
  input  lrl_pkg::cmd_t      cmd,
  output lrl_pkg::status_t   status,
  lrl_out_if.source          res
);
  import lrl_pkg::*;

  localparam int RW = 64 + 16 + 32;
  localparam int FW = 64 + 16 + 32 + 16;

  logic [15:0] fail_threshold, backoff_base, backoff_cap, rate_count, rate_window;
  logic [19:0] evict_after;

  always_ff @(posedge clk) begin
    if (rst) begin
      fail_threshold <= 16'd5;
      backoff_base   <= 16'd10;
      backoff_cap    <= 16'd300;
      evict_after    <= 20'd3600;
      rate_count     <= 16'd60;
      rate_window    <= 16'd60;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FAIL_THRESHOLD: fail_threshold <= cfg_data[15:0];
        REG_BASE_DELAY:     backoff_base   <= cfg_data[15:0];
        REG_MAX_DELAY:      backoff_cap    <= cfg_data[15:0];
        REG_EVICTION_TIME:  evict_after    <= cfg_data;
        REG_RATE_COUNT:     rate_count     <= cfg_data[15:0];
        REG_RATE_WINDOW:    rate_window    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // latched attempt
  logic [63:0] key_r;
  logic [31:0] now_r;
  logic        ok_r;
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key_r <= in_key;
      now_r <= in_now;
      ok_r  <= in_ok;
    end
  end

  // tables
  logic [RW-1:0] rmem [N];
  logic [FW-1:0] fmem [N];
  logic [N-1:0]  rvalid, fvalid;
  logic [N-1:0]  fvalid_next;
  logic [RW-1:0] rrd;
  logic [FW-1:0] frd;

  logic [CW-1:0] cnt;
  logic [IW-1:0] rd_idx;
  logic          rd_vld;
  logic          rd_issue;

  assign rd_issue = cmd.scan && (cnt < CW'(N));

  always_ff @(posedge clk) begin
    if (rd_issue) begin
      rrd <= rmem[cnt[IW-1:0]];
      frd <= fmem[cnt[IW-1:0]];
    end
  end

  logic [63:0] rd_rkey, rd_fkey;
  logic [31:0] rd_rstart, rd_ftime;
  logic [15:0] rd_rcnt, rd_fcnt, rd_fdelay;
  logic [31:0] rd_rel;
  assign {rd_rkey, rd_rcnt, rd_rstart}           = rrd;
  assign {rd_fkey, rd_fcnt, rd_ftime, rd_fdelay} = frd;
  assign rd_rel = now_r - rd_rstart;

  // search results
  logic          rhit_f, rfree_f, rexp_f, fhit_f, ffree_f;
  logic [IW-1:0] rhit_i, rfree_i, rexp_i, fhit_i, ffree_i;
  logic [15:0]   rhit_cnt, fhit_cnt, fhit_delay;
  logic [31:0]   rhit_start, fhit_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0; rd_vld <= 1'b0;
      rhit_f <= 1'b0; rfree_f <= 1'b0; rexp_f <= 1'b0;
      fhit_f <= 1'b0; ffree_f <= 1'b0;
    end else if (cmd.start) begin
      cnt <= '0; rd_vld <= 1'b0;
      rhit_f <= 1'b0; rfree_f <= 1'b0; rexp_f <= 1'b0;
      fhit_f <= 1'b0; ffree_f <= 1'b0;
    end else if (cmd.scan) begin
      rd_vld <= rd_issue;
      if (rd_issue) begin
        rd_idx <= cnt[IW-1:0];
        cnt    <= cnt + 1'b1;
      end
      if (rd_vld) begin
        if (rvalid[rd_idx]) begin
          if (!rhit_f && rd_rkey == key_r) begin
            rhit_f <= 1'b1; rhit_i <= rd_idx;
            rhit_cnt <= rd_rcnt; rhit_start <= rd_rstart;
          end else if (!rexp_f && rd_rel > {16'd0, rate_window}) begin
            rexp_f <= 1'b1; rexp_i <= rd_idx;
          end
        end else if (!rfree_f) begin
          rfree_f <= 1'b1; rfree_i <= rd_idx;
        end
        if (fvalid[rd_idx]) begin
          if (!fhit_f && rd_fkey == key_r) begin
            fhit_f <= 1'b1; fhit_i <= rd_idx;
            fhit_cnt <= rd_fcnt; fhit_time <= rd_ftime; fhit_delay <= rd_fdelay;
          end
        end else if (!ffree_f) begin
          ffree_f <= 1'b1; ffree_i <= rd_idx;
        end
      end
    end
  end

  assign status.scan_done = (cnt == CW'(N)) && !rd_vld;

  // rate stage
  logic [31:0]   r_el;
  logic          r_in;
  logic [15:0]   r_cnt;
  logic [IW-1:0] r_slot;
  logic          r_wr;
  logic          over_r, full_r;

  always_comb begin
    r_el  = now_r - rhit_start;
    r_in  = r_el <= {16'd0, rate_window};
    r_cnt = 16'd1;
    if (rhit_f && r_in) r_cnt = (rhit_cnt != CNT_MAX) ? rhit_cnt + 16'd1 : CNT_MAX;
    r_slot = rhit_f ? rhit_i : (rfree_f ? rfree_i : rexp_i);
    r_wr   = rhit_f || rfree_f || rexp_f;
  end

  always_ff @(posedge clk) begin
    if (cmd.rate && r_wr)
      rmem[r_slot] <= {key_r, r_cnt, (rhit_f && r_in) ? rhit_start : now_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.rate) begin
      over_r <= r_cnt > rate_count;
      full_r <= !r_wr;
    end
  end

  // failure stage
  logic [31:0]   f_el;
  logic          f_evict, f_live, f_cool, f_has, f_wr;
  logic [15:0]   tot0, tot, d0, capd, fd;
  logic [16:0]   dbl;
  logic [IW-1:0] f_slot;

  always_comb begin
    f_el    = now_r - fhit_time;
    f_evict = fhit_f && (f_el > {12'd0, evict_after});
    f_live  = fhit_f && !f_evict;
    f_cool  = f_live && (f_el < {16'd0, fhit_delay});
    tot0    = f_live ? fhit_cnt : 16'd0;
    tot     = (tot0 != CNT_MAX) ? tot0 + 16'd1 : tot0;
    d0      = f_live ? fhit_delay : 16'd0;
    dbl     = (d0 == 16'd0) ? {1'b0, backoff_base} : {d0, 1'b0};
    capd    = (dbl > {1'b0, backoff_cap}) ? backoff_cap : dbl[15:0];
    fd      = (tot >= fail_threshold) ? capd : d0;
    if (f_live || (f_evict && (!ffree_f || fhit_i < ffree_i))) f_slot = fhit_i;
    else                                                       f_slot = ffree_i;
    f_has = f_live || f_evict || ffree_f;
    f_wr  = cmd.fail && !over_r && !f_cool && !ok_r && f_has;
  end

  always_ff @(posedge clk) begin
    if (f_wr) fmem[f_slot] <= {key_r, tot, now_r, fd};
  end

  always_comb begin
    fvalid_next = fvalid;
    if (cmd.fail && !over_r && !f_cool) begin
      if (fhit_f && (ok_r || f_evict)) fvalid_next[fhit_i] = 1'b0;
      if (f_wr) fvalid_next[f_slot] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rvalid <= '0;
      fvalid <= '0;
    end else begin
      if (cmd.rate && r_wr) rvalid[r_slot] <= 1'b1;
      fvalid <= fvalid_next;
    end
  end

  // output register
  logic out_valid;
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.fail) out_valid <= 1'b1;
    else if (res.ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.fail) begin
      priority if (over_r) begin
        res.verdict <= V_RATE; res.fail_total <= '0; res.cooldown <= '0;
        res.table_full <= full_r;
      end else if (f_cool) begin
        res.verdict <= V_COOLDOWN; res.fail_total <= fhit_cnt;
        res.cooldown <= fhit_delay; res.table_full <= full_r;
      end else if (ok_r) begin
        res.verdict <= V_ALLOW; res.fail_total <= '0; res.cooldown <= '0;
        res.table_full <= full_r;
      end else begin
        res.verdict <= V_BAD_PW; res.fail_total <= tot; res.cooldown <= fd;
        res.table_full <= full_r || !f_has;
      end
    end
  end

  assign res.valid       = out_valid;
  assign status.out_busy = out_valid && !res.ready;

  a_rhit_valid: assert property (@(posedge clk) disable iff (rst)
    rhit_f |-> rvalid[rhit_i]) else $error("rate hit on empty slot");
  a_rd_bound: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> $past(cnt) < CW'(N)) else $error("scan read past table end");
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.fail)) else $error("result without fail stage");

endmodule
